// ----- design/bgg_pkg.sv -----
// shared types and constants for the bilinear grid gradient pixel block
package bgg_pkg;

    localparam int MAX_GRID_DEF = 16;
    localparam int MAX_DIM_DEF  = 4096;
    localparam int FIFO_DEPTH   = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int GRID_W       = 5;
    localparam int CORNER_W     = 5;
    localparam int COLOR_W      = 24;
    localparam int PIX_W        = 12;
    localparam int ADDR_W       = 24;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 3;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [GRID_W-1:0]     RST_GRID_CELLS   = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_GRID_CELLS   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    typedef struct packed {
        logic                is_pix;
        logic                ld_ok;
        logic [CORNER_W-1:0] corner_row;
        logic [CORNER_W-1:0] corner_col;
        logic [COLOR_W-1:0]  color;
        logic [PIX_W-1:0]    pixel_col;
        logic [PIX_W-1:0]    pixel_row;
        logic                in_area;
    } t_job;

endpackage

// ----- design/bgg_if.sv -----
// channel interfaces for input words, result words and configuration writes
interface bgg_in_if import bgg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [CORNER_W-1:0] corner_row;
    logic [CORNER_W-1:0] corner_col;
    logic [COLOR_W-1:0]  corner_color;
    logic [PIX_W-1:0]    pixel_col;
    logic [PIX_W-1:0]    pixel_row;

    modport source (output valid, action, corner_row, corner_col, corner_color,
                    pixel_col, pixel_row, input ready);
    modport sink (input valid, action, corner_row, corner_col, corner_color,
                  pixel_col, pixel_row, output ready);
endinterface

interface bgg_out_if import bgg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [ADDR_W-1:0]  pixel_address;
    logic               covered;

    modport source (output valid, pixel_color, pixel_address, covered, input ready);
    modport sink (input valid, pixel_color, pixel_address, covered, output ready);
endinterface

interface bgg_cfg_if import bgg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/bgg_ram.sv -----
// generic single write port ram with registered read
module bgg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 289,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bgg_front.sv -----
// front end: configuration registers, cell geometry divider, word classification
module bgg_front import bgg_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF,
    localparam int DW = $clog2(MAX_DIM + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bgg_in_if.sink          i_pix,
    bgg_cfg_if.sink         i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output t_job            o_job,
    output logic [DW-1:0]   o_cw,
    output logic [DW-1:0]   o_ch,
    output logic [DW-1:0]   o_wc,
    output logic [2*DW-1:0] o_area
);
    localparam int GW   = $clog2(MAX_GRID + 1);
    localparam int CNTW = $clog2(DW + 1);
    localparam int CMPW = (DW > PIX_W) ? DW : PIX_W;

    logic [CFG_DATA_W-1:0] r_w, r_h;
    logic [GRID_W-1:0]     r_g;
    logic                  r_start, r_run, r_ok;
    logic [CNTW-1:0]       r_cnt;
    logic [DW-1:0]         r_qw, r_qh;
    logic [GW:0]           r_rw, r_rh;
    logic [GW-1:0]         r_gd;
    logic [DW-1:0]         r_cw, r_ch, r_gw, r_gh;
    logic [2*DW-1:0]       r_area;

    logic [DW-1:0]   wc, hc;
    logic [GW-1:0]   gc;
    logic [GW:0]     tw, th, n_rw, n_rh;
    logic            ge_w, ge_h;
    logic [DW-1:0]   n_qw, n_qh;
    logic [2*DW-1:0] area_full;
    logic            cfg_wr;

    assign wc = (32'(r_w) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_w);
    assign hc = (32'(r_h) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_h);
    assign gc = (32'(r_g) > MAX_GRID) ? GW'(MAX_GRID) : GW'(r_g);

    // one quotient bit per cycle for width and height
    always_comb begin
        tw   = {r_rw[GW-1:0], r_qw[DW-1]};
        th   = {r_rh[GW-1:0], r_qh[DW-1]};
        ge_w = (tw >= {1'b0, r_gd});
        ge_h = (th >= {1'b0, r_gd});
        n_rw = ge_w ? tw - {1'b0, r_gd} : tw;
        n_rh = ge_h ? th - {1'b0, r_gd} : th;
        n_qw = {r_qw[DW-2:0], ge_w};
        n_qh = {r_qh[DW-2:0], ge_h};
    end

    assign area_full = {{DW{1'b0}}, r_qw} * {{DW{1'b0}}, r_qh};
    assign cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= RST_FRAME_WIDTH;
            r_h     <= RST_FRAME_HEIGHT;
            r_g     <= RST_GRID_CELLS;
            r_start <= 1'b1;
            r_run   <= 1'b0;
            r_ok    <= 1'b0;
            r_cnt   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_w <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_h <= i_cfg.data;
                CFG_GRID_CELLS:   r_g <= i_cfg.data[GRID_W-1:0];
                default: ;
            endcase
            r_start <= 1'b1;
            r_run   <= 1'b0;
        end else if (r_start) begin
            r_start <= 1'b0;
            r_run   <= 1'b1;
            r_cnt   <= CNTW'(DW);
            r_qw    <= wc;
            r_qh    <= hc;
            r_rw    <= '0;
            r_rh    <= '0;
            r_gd    <= gc;
        end else if (r_run) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_qw  <= n_qw;
                r_qh  <= n_qh;
                r_rw  <= n_rw;
                r_rh  <= n_rh;
            end else begin
                r_run  <= 1'b0;
                r_cw   <= r_qw;
                r_ch   <= r_qh;
                r_gw   <= DW'(r_gd * r_qw);
                r_gh   <= DW'(r_gd * r_qh);
                r_area <= area_full;
                r_ok   <= (r_gd != '0) && (r_qw != '0) && (r_qh != '0);
            end
        end
    end

    assign i_pix.ready = !r_start && !r_run && !i_full;
    assign o_push      = i_pix.valid && i_pix.ready;

    always_comb begin
        o_job.is_pix     = (i_pix.action == ACT_PIXEL);
        o_job.ld_ok      = (32'(i_pix.corner_row) <= MAX_GRID)
                           && (32'(i_pix.corner_col) <= MAX_GRID);
        o_job.corner_row = i_pix.corner_row;
        o_job.corner_col = i_pix.corner_col;
        o_job.color      = i_pix.corner_color;
        o_job.pixel_col  = i_pix.pixel_col;
        o_job.pixel_row  = i_pix.pixel_row;
        o_job.in_area    = r_ok && (CMPW'(i_pix.pixel_col) < CMPW'(r_gw))
                           && (CMPW'(i_pix.pixel_row) < CMPW'(r_gh));
    end

    assign o_cw   = r_cw;
    assign o_ch   = r_ch;
    assign o_wc   = wc;
    assign o_area = r_area;
endmodule

// ----- design/bgg_fifo.sv -----
// short word queue between front and back end
module bgg_fifo import bgg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_vld,
    output t_job o_job
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_job          r_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full = (r_cnt == CW'(FIFO_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_job  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_vld)) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(FIFO_DEPTH)) else $error("queue count out of range");
endmodule

// ----- design/bgg_back.sv -----
// back end: cell search, corner reads, weighting and per channel division
module bgg_back import bgg_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF,
    localparam int DW = $clog2(MAX_DIM + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fifo_vld,
    input  t_job            i_fifo_job,
    output logic            o_pop,
    input  logic [DW-1:0]   i_cw,
    input  logic [DW-1:0]   i_ch,
    input  logic [DW-1:0]   i_wc,
    input  logic [2*DW-1:0] i_area,
    bgg_out_if.source       o_pix
);
    localparam int QW    = $clog2(MAX_GRID + 1);
    localparam int SIDE  = MAX_GRID + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (DW + QW > PIX_W) ? DW + QW : PIX_W;
    localparam int WW    = 2 * DW;
    localparam int SW    = 2 * DW + CHAN_W;
    localparam int APW   = PIX_W + DW;
    localparam int NQ    = CHAN_W;

    logic adv;

    // cell search stages
    logic          r_dv_vld [0:QW];
    t_job          r_dv_job [0:QW];
    logic [RW-1:0] r_rx [0:QW];
    logic [RW-1:0] r_ry [0:QW];
    logic [QW-1:0] r_qx [0:QW];
    logic [QW-1:0] r_qy [0:QW];
    logic [RW-1:0] dv_x [0:QW-1];
    logic [RW-1:0] dv_y [0:QW-1];
    logic [RW-1:0] n_rx [0:QW-1];
    logic [RW-1:0] n_ry [0:QW-1];
    logic [QW-1:0] n_qx [0:QW-1];
    logic [QW-1:0] n_qy [0:QW-1];

    // corner read and weights
    logic [AW-1:0]      addr00, addr01, addr10, addr11, waddr;
    logic               we;
    logic [DW-1:0]      x_s, y_s;
    logic [COLOR_W-1:0] rd00, rd01, rd10, rd11;

    logic          r_a_vld;
    t_job          r_a_job;
    logic [DW-1:0] r_a_dx, r_a_dy, r_a_x, r_a_y;

    logic               r_b_vld;
    t_job               r_b_job;
    logic [WW-1:0]      r_b_w [0:3];
    logic [COLOR_W-1:0] r_b_c [0:3];
    logic [APW-1:0]     r_b_ap;

    logic              r_c_vld;
    t_job              r_c_job;
    logic [SW-1:0]     r_c_p [0:NUM_CHAN-1][0:3];
    logic [ADDR_W-1:0] r_c_addr;

    // per channel quotient stages
    logic              r_q_vld [0:NQ];
    t_job              r_q_job [0:NQ];
    logic [ADDR_W-1:0] r_q_addr [0:NQ];
    logic [SW-1:0]     r_q_rem [0:NQ][0:NUM_CHAN-1];
    logic [CHAN_W-1:0] r_q_quo [0:NQ][0:NUM_CHAN-1];
    logic [SW-1:0]     dv_q [0:NQ-1];
    logic [SW-1:0]     n_rem [0:NQ-1][0:NUM_CHAN-1];
    logic [CHAN_W-1:0] n_quo [0:NQ-1][0:NUM_CHAN-1];

    logic               r_out_vld;
    logic [COLOR_W-1:0] r_out_color;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_cov;

    assign adv   = !r_out_vld || o_pix.ready;
    assign o_pop = adv && i_fifo_vld;

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            dv_x[s] = RW'(i_cw) << (QW - 1 - s);
            dv_y[s] = RW'(i_ch) << (QW - 1 - s);
            if (r_rx[s] >= dv_x[s]) begin
                n_rx[s] = r_rx[s] - dv_x[s];
                n_qx[s] = r_qx[s] | (QW'(1) << (QW - 1 - s));
            end else begin
                n_rx[s] = r_rx[s];
                n_qx[s] = r_qx[s];
            end
            if (r_ry[s] >= dv_y[s]) begin
                n_ry[s] = r_ry[s] - dv_y[s];
                n_qy[s] = r_qy[s] | (QW'(1) << (QW - 1 - s));
            end else begin
                n_ry[s] = r_ry[s];
                n_qy[s] = r_qy[s];
            end
        end
    end

    // column offset blends corner rows, row offset blends corner columns
    assign addr00 = AW'(32'(r_qy[QW]) * SIDE + 32'(r_qx[QW]));
    assign addr01 = AW'(32'(r_qy[QW]) * SIDE + 32'(r_qx[QW]) + 1);
    assign addr10 = AW'((32'(r_qy[QW]) + 1) * SIDE + 32'(r_qx[QW]));
    assign addr11 = AW'((32'(r_qy[QW]) + 1) * SIDE + 32'(r_qx[QW]) + 1);
    assign waddr  = AW'(32'(r_dv_job[QW].corner_row) * SIDE
                        + 32'(r_dv_job[QW].corner_col));
    assign we     = adv && r_dv_vld[QW] && !r_dv_job[QW].is_pix && r_dv_job[QW].ld_ok;
    assign x_s    = DW'(r_rx[QW]);
    assign y_s    = DW'(r_ry[QW]);

    bgg_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram00 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_dv_job[QW].color),
        .i_re(adv), .i_raddr(addr00), .o_rdata(rd00)
    );
    bgg_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram01 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_dv_job[QW].color),
        .i_re(adv), .i_raddr(addr01), .o_rdata(rd01)
    );
    bgg_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram10 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_dv_job[QW].color),
        .i_re(adv), .i_raddr(addr10), .o_rdata(rd10)
    );
    bgg_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram11 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_dv_job[QW].color),
        .i_re(adv), .i_raddr(addr11), .o_rdata(rd11)
    );

    always_comb begin
        for (int s = 0; s < NQ; s++) begin
            dv_q[s] = SW'(i_area) << (NQ - 1 - s);
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (r_q_rem[s][c] >= dv_q[s]) begin
                    n_rem[s][c] = r_q_rem[s][c] - dv_q[s];
                    n_quo[s][c] = r_q_quo[s][c] | (CHAN_W'(1) << (NQ - 1 - s));
                end else begin
                    n_rem[s][c] = r_q_rem[s][c];
                    n_quo[s][c] = r_q_quo[s][c];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) begin
                r_dv_vld[s] <= 1'b0;
            end
            for (int s = 0; s <= NQ; s++) begin
                r_q_vld[s] <= 1'b0;
            end
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= i_fifo_vld;
            for (int s = 0; s < QW; s++) begin
                r_dv_vld[s+1] <= r_dv_vld[s];
            end
            r_a_vld    <= r_dv_vld[QW];
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_q_vld[0] <= r_c_vld;
            for (int s = 0; s < NQ; s++) begin
                r_q_vld[s+1] <= r_q_vld[s];
            end
            r_out_vld <= r_q_vld[NQ] && r_q_job[NQ].is_pix;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_job[0] <= i_fifo_job;
            r_rx[0]     <= RW'(i_fifo_job.pixel_col);
            r_ry[0]     <= RW'(i_fifo_job.pixel_row);
            r_qx[0]     <= '0;
            r_qy[0]     <= '0;
            for (int s = 0; s < QW; s++) begin
                r_dv_job[s+1] <= r_dv_job[s];
                r_rx[s+1]     <= n_rx[s];
                r_ry[s+1]     <= n_ry[s];
                r_qx[s+1]     <= n_qx[s];
                r_qy[s+1]     <= n_qy[s];
            end

            r_a_job <= r_dv_job[QW];
            r_a_dx  <= i_cw - x_s;
            r_a_dy  <= i_ch - y_s;
            r_a_x   <= x_s;
            r_a_y   <= y_s;

            r_b_job  <= r_a_job;
            r_b_w[0] <= WW'(r_a_dx) * WW'(r_a_dy);
            r_b_w[1] <= WW'(r_a_x) * WW'(r_a_dy);
            r_b_w[2] <= WW'(r_a_dx) * WW'(r_a_y);
            r_b_w[3] <= WW'(r_a_x) * WW'(r_a_y);
            r_b_c[0] <= rd00;
            r_b_c[1] <= rd10;
            r_b_c[2] <= rd01;
            r_b_c[3] <= rd11;
            r_b_ap   <= APW'(r_a_job.pixel_row) * APW'(i_wc);

            r_c_job <= r_b_job;
            for (int c = 0; c < NUM_CHAN; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_c_p[c][k] <= SW'(r_b_w[k]) * SW'(r_b_c[k][CHAN_W*c +: CHAN_W]);
                end
            end
            r_c_addr <= ADDR_W'(r_b_ap + APW'(r_b_job.pixel_col));

            r_q_job[0]  <= r_c_job;
            r_q_addr[0] <= r_c_addr;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_q_rem[0][c] <= r_c_p[c][0] + r_c_p[c][1] + r_c_p[c][2] + r_c_p[c][3];
                r_q_quo[0][c] <= '0;
            end
            for (int s = 0; s < NQ; s++) begin
                r_q_job[s+1]  <= r_q_job[s];
                r_q_addr[s+1] <= r_q_addr[s];
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_q_rem[s+1][c] <= n_rem[s][c];
                    r_q_quo[s+1][c] <= n_quo[s][c];
                end
            end

            r_out_addr  <= r_q_addr[NQ];
            r_out_cov   <= r_q_job[NQ].in_area;
            r_out_color <= r_q_job[NQ].in_area
                           ? {r_q_quo[NQ][2], r_q_quo[NQ][1], r_q_quo[NQ][0]} : '0;
        end
    end

    assign o_pix.valid         = r_out_vld;
    assign o_pix.pixel_color   = r_out_color;
    assign o_pix.pixel_address = r_out_addr;
    assign o_pix.covered       = r_out_cov;

    a_col_offset_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[QW] && r_dv_job[QW].is_pix && r_dv_job[QW].in_area
        |-> r_rx[QW] < RW'(i_cw)) else $error("column offset outside cell");
    a_row_offset_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[QW] && r_dv_job[QW].is_pix && r_dv_job[QW].in_area
        |-> r_ry[QW] < RW'(i_ch)) else $error("row offset outside cell");
    a_blend_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld[NQ] && r_q_job[NQ].is_pix && r_q_job[NQ].in_area
        |-> r_q_rem[NQ][0] < SW'(i_area) && r_q_rem[NQ][2] < SW'(i_area))
        else $error("blend quotient exceeds eight bits");
endmodule

// ----- design/bilinear_grid_gradient_pixel.sv -----
// top level of the bilinear grid gradient pixel generator
//
// i_pix carries words of two kinds: a load writes one corner color of the
// (G+1)x(G+1) grid, a pixel request asks for the interpolated color at a
// column and row. Every pixel request yields one word on o_pix with the
// color, the linear address row*width+col and a covered flag; loads yield
// nothing. i_cfg writes frame width, frame height and grid cell count.
// A new input word is accepted every cycle while the cell size divider is
// idle and the queue is not full. An accepted pixel word passes through
// the queue, one cell search stage per quotient bit (QW = bits of
// MAX_GRID+1), corner read, weights, channel products, sum, eight stages
// of per channel division and the output register.
// After reset and after each configuration write the cell size is worked
// out by a bit-serial divider over DW quotient bits (DW = bits of
// MAX_DIM+1), with i_pix.ready low. Corner colors are undefined after
// reset until loaded.
// When o_pix is stalled the whole back end holds; the front keeps accepting
// words into the four-entry queue until it fills.
module bilinear_grid_gradient_pixel import bgg_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgg_in_if.sink     i_pix,
    bgg_out_if.source  o_pix,
    bgg_cfg_if.sink    i_cfg
);
    localparam int DW = $clog2(MAX_DIM + 1);

    logic            push, full, fifo_vld, pop;
    t_job            push_job, fifo_job;
    logic [DW-1:0]   cw, ch, wc;
    logic [2*DW-1:0] area;

    bgg_front #(.MAX_GRID(MAX_GRID), .MAX_DIM(MAX_DIM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(i_pix), .i_cfg(i_cfg),
        .i_full(full), .o_push(push), .o_job(push_job),
        .o_cw(cw), .o_ch(ch), .o_wc(wc), .o_area(area)
    );

    bgg_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .o_full(full), .i_pop(pop), .o_vld(fifo_vld), .o_job(fifo_job)
    );

    bgg_back #(.MAX_GRID(MAX_GRID), .MAX_DIM(MAX_DIM)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fifo_vld(fifo_vld),
        .i_fifo_job(fifo_job), .o_pop(pop), .i_cw(cw), .i_ch(ch),
        .i_wc(wc), .i_area(area), .o_pix(o_pix)
    );
endmodule

// ----- tb/bilinear_grid_gradient_pixel_chk.sv -----
// checker: watches the channels, predicts pixel words and compares them
`timescale 1ns / 1ps
module bilinear_grid_gradient_pixel_chk import bgg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgg_in_if.sink     i_pix,
    bgg_out_if.sink    o_pix,
    bgg_cfg_if.sink    i_cfg,
    output int         o_errors,
    output int         o_pending,
    output int         o_seen
);
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
        logic               cov;
    } t_pixel_exp;

    logic [COLOR_W-1:0] corners [0:MAX_GRID_DEF][0:MAX_GRID_DEF];
    logic [12:0]        width_q, height_q;
    logic [4:0]         grid_q;
    t_pixel_exp         pixel_q [$];

    function automatic logic [7:0] blend(input int sh, input logic [23:0] c00,
                                         input logic [23:0] c10, input logic [23:0] c01,
                                         input logic [23:0] c11, input longint cw,
                                         input longint ch, input longint x,
                                         input longint y);
        longint s;
        s = (cw - x) * (ch - y) * ((c00 >> sh) & 8'hff) + x * (ch - y) * ((c10 >> sh) & 8'hff)
            + (cw - x) * y * ((c01 >> sh) & 8'hff) + x * y * ((c11 >> sh) & 8'hff);
        s = s / (cw * ch);
        return (s > 255) ? 8'hff : s[7:0];
    endfunction

    function automatic t_pixel_exp interp_pixel(input logic [11:0] pc, input logic [11:0] pr);
        t_pixel_exp e;
        longint w, h, g, cw, ch, i, j, x, y;
        w = (width_q > MAX_DIM_DEF) ? MAX_DIM_DEF : width_q;
        h = (height_q > MAX_DIM_DEF) ? MAX_DIM_DEF : height_q;
        g = (grid_q > MAX_GRID_DEF) ? MAX_GRID_DEF : grid_q;
        e.addr = 24'(longint'(pr) * w + pc);
        e.color = '0;
        e.cov = 1'b0;
        if (g != 0) begin
            cw = w / g;
            ch = h / g;
            if (cw != 0 && ch != 0 && pc < g * cw && pr < g * ch) begin
                i = pr / ch;
                j = pc / cw;
                x = pc - j * cw;
                y = pr - i * ch;
                for (int k = 0; k < 3; k++)
                    e.color[k*8 +: 8] = blend(k * 8, corners[i][j], corners[i+1][j],
                                              corners[i][j+1], corners[i+1][j+1],
                                              cw, ch, x, y);
                e.cov = 1'b1;
            end
        end
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        t_pixel_exp e;
        if (!i_rst_n) begin
            width_q <= RST_FRAME_WIDTH;
            height_q <= RST_FRAME_HEIGHT;
            grid_q <= RST_GRID_CELLS;
            o_errors <= 0;
            o_seen <= 0;
            pixel_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH: width_q <= i_cfg.data;
                    CFG_FRAME_HEIGHT: height_q <= i_cfg.data;
                    CFG_GRID_CELLS: grid_q <= i_cfg.data[4:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                if (t_action'(i_pix.action) == ACT_LOAD) begin
                    if (i_pix.corner_row <= MAX_GRID_DEF && i_pix.corner_col <= MAX_GRID_DEF)
                        corners[i_pix.corner_row][i_pix.corner_col] <= i_pix.corner_color;
                end else begin
                    pixel_q.push_back(interp_pixel(i_pix.pixel_col, i_pix.pixel_row));
                end
            end
            if (o_pix.valid && o_pix.ready) begin
                o_seen <= o_seen + 1;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected word color %h addr %h cov %b", $time,
                             o_pix.pixel_color, o_pix.pixel_address, o_pix.covered);
                    o_errors <= o_errors + 1;
                end else begin
                    e = pixel_q.pop_front();
                    if (e.color !== o_pix.pixel_color || e.addr !== o_pix.pixel_address
                        || e.cov !== o_pix.covered) begin
                        $display("%0t: mismatch expected %h/%h/%b actual %h/%h/%b", $time,
                                 e.color, e.addr, e.cov, o_pix.pixel_color,
                                 o_pix.pixel_address, o_pix.covered);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = pixel_q.size();
endmodule

// ----- tb/bilinear_grid_gradient_pixel_tb.sv -----
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module bilinear_grid_gradient_pixel_tb;
    import bgg_pkg::*;

    logic i_clk, i_rst_n;
    logic hold_req;
    int   errors, pending, seen, hold_off, stall_mode;
    int   loaded_g;

    bgg_in_if  pix_in ();
    bgg_out_if pix_out ();
    bgg_cfg_if cfg ();

    bilinear_grid_gradient_pixel DUT (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_in),
                                      .o_pix(pix_out), .i_cfg(cfg));
    bilinear_grid_gradient_pixel_chk CHK (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_in),
                                          .o_pix(pix_out), .i_cfg(cfg), .o_errors(errors),
                                          .o_pending(pending), .o_seen(seen));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            hold_off <= 0;
        end else if (hold_off > 0) begin
            pix_out.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (hold_req) begin
            pix_out.ready <= 1'b0;
            hold_off <= 300;
        end else case (stall_mode)
            0: pix_out.ready <= 1'b1;
            1: pix_out.ready <= ($urandom_range(0, 3) != 0);
            default: pix_out.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    task automatic send_word(input logic act, input int r, input int c,
                             input int col, input int pc, input int pr);
        pix_in.valid <= 1'b1;
        pix_in.action <= act;
        pix_in.corner_row <= 5'(r);
        pix_in.corner_col <= 5'(c);
        pix_in.corner_color <= 24'(col);
        pix_in.pixel_col <= 12'(pc);
        pix_in.pixel_row <= 12'(pr);
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            pix_in.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= 13'(val);
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_grid(input int g);
        for (int r = 0; r <= g; r++)
            for (int c = 0; c <= g; c++) begin
                send_word(ACT_LOAD, r, c, $urandom, $urandom, $urandom);
                idle_gap();
            end
    endtask

    task automatic random_pixels(input int n);
        int burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(ACT_LOAD, $urandom_range(0, 31), $urandom_range(0, 31), $urandom,
                          $urandom, $urandom);
            else if ($urandom_range(0, 9) == 0)
                send_word(ACT_LOAD, $urandom_range(0, loaded_g), $urandom_range(0, loaded_g),
                          $urandom, $urandom, $urandom);
            else
                send_word(ACT_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                pix_in.valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end else burst--;
        end
    endtask

    initial begin
        pix_in.valid = 0;
        pix_in.action = 0;
        pix_in.corner_row = 0;
        pix_in.corner_col = 0;
        pix_in.corner_color = 0;
        pix_in.pixel_col = 0;
        pix_in.pixel_row = 0;
        cfg.valid = 0;
        cfg.index = CFG_FRAME_WIDTH;
        cfg.data = 0;
        hold_req = 0;
        stall_mode = 0;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: full grid at reset setting, corner cases of pixels
        loaded_g = MAX_GRID_DEF;
        load_grid(MAX_GRID_DEF);
        send_word(ACT_LOAD, 31, 0, 24'hffffff, 0, 0);
        send_word(ACT_LOAD, 0, 17, 24'h000000, 0, 0);
        send_word(ACT_PIXEL, 0, 0, 0, 0, 0);
        send_word(ACT_PIXEL, 0, 0, 0, 639, 479);
        send_word(ACT_PIXEL, 0, 0, 0, 640, 0);
        send_word(ACT_PIXEL, 0, 0, 0, 4095, 4095);
        send_word(ACT_PIXEL, 0, 0, 0, 79, 59);
        send_word(ACT_PIXEL, 0, 0, 0, 80, 60);
        stall_mode = 1;
        random_pixels(60);
        // long receiver hold-off so the queue fills and input stalls
        pix_in.valid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        random_pixels(40);
        drain();
        // extremes: max dims, grid over limit, grid zero, tiny frame, zero cell size, odd frame, random setting
        write_reg(CFG_FRAME_WIDTH, 8191);
        write_reg(CFG_FRAME_HEIGHT, 4096);
        write_reg(CFG_GRID_CELLS, 31);
        stall_mode = 2;
        random_pixels(50);
        drain();
        write_reg(CFG_GRID_CELLS, 0);
        random_pixels(30);
        drain();
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 1);
        write_reg(CFG_GRID_CELLS, 1);
        random_pixels(30);
        send_word(ACT_PIXEL, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_FRAME_WIDTH, 10);
        write_reg(CFG_FRAME_HEIGHT, 12);
        write_reg(CFG_GRID_CELLS, 16);
        random_pixels(30);
        drain();
        write_reg(CFG_FRAME_WIDTH, 23);
        write_reg(CFG_FRAME_HEIGHT, 17);
        write_reg(CFG_GRID_CELLS, 3);
        stall_mode = 0;
        for (int k = 0; k < 60; k++) begin
            send_word(ACT_PIXEL, 0, 0, 0, $urandom_range(0, 25), $urandom_range(0, 20));
            idle_gap();
        end
        stall_mode = 1;
        drain();
        write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 4096));
        write_reg(CFG_FRAME_HEIGHT, $urandom_range(1, 4096));
        write_reg(CFG_GRID_CELLS, $urandom_range(1, 16));
        random_pixels(60);
        drain();
        $display("covered corner loads, grid and frame extremes, stalls; %0d pixel words checked",
                 seen);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
